### rtl/core/lpf_pkg.sv
package lpf_pkg;

    localparam int FRAME_LEN = 11;
    localparam int TIME_BYTES = 8;

    localparam logic [7:0] MARK0 = 8'h73;  // 's'
    localparam logic [7:0] MARK1 = 8'h6C;  // 'l'

    // Byte positions inside a probe frame.
    localparam logic [3:0] IDX_MARK0 = 4'd0;
    localparam logic [3:0] IDX_MARK1 = 4'd1;
    localparam logic [3:0] IDX_TIME0 = 4'd2;
    localparam logic [3:0] IDX_CHK   = 4'd10;

    // Result kinds.
    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_LAT = 1'b1;

    // Request kinds.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [16:0] INTERVAL_RESET = 17'd30000;

    typedef struct packed {
        logic        match;
        logic [63:0] sent_ms;
    } lpf_rx_hit_t;

endpackage

### rtl/core/lpf_rx_window.sv
module lpf_rx_window
    import lpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [7:0]  rx_byte,
    output lpf_rx_hit_t hit,
    output logic [3:0]  fill
);

    logic [7:0] window_reg  [FRAME_LEN];
    logic [7:0] window_next [FRAME_LEN];
    logic [7:0] merged      [FRAME_LEN];
    logic [3:0] fill_reg;
    logic [3:0] fill_next;
    logic       full;
    logic [7:0] chk;
    logic       match;

    // The window as it looks with the incoming byte placed at the fill point.
    always_comb begin
        chk = '0;
        for (int i = 0; i < FRAME_LEN; i++) begin
            merged[i] = (fill_reg == 4'(i)) ? rx_byte : window_reg[i];
            chk = chk ^ merged[i];
        end
    end

    assign full  = (fill_reg == IDX_CHK);
    assign match = full && (merged[0] == MARK0) && (merged[1] == MARK1) && (chk == 8'h00);

    always_comb begin
        hit.match = match;
        for (int i = 0; i < TIME_BYTES; i++) begin
            hit.sent_ms[8*i +: 8] = merged[int'(IDX_TIME0) + i];
        end
    end

    always_comb begin
        window_next = window_reg;
        fill_next   = fill_reg;
        if (wr_en) begin
            if (!full) begin
                window_next = merged;
                fill_next   = fill_reg + 4'd1;
            end else if (match) begin
                fill_next = '0;
            end else begin
                // Oldest byte slides out; the window stays one short of full.
                for (int i = 0; i < FRAME_LEN - 1; i++) begin
                    window_next[i] = merged[i + 1];
                end
                window_next[FRAME_LEN - 1] = '0;
                fill_next = IDX_CHK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign fill = fill_reg;

endmodule

### rtl/core/latency_probe_framer_top.sv
// An input item passes the input register, then the result register, before its result
// is offered for transfer.
// Throughput: one input item per cycle; a sending tick holds the result register for
// eleven output transfers, and an item that yields a result waits behind it. Items that
// yield nothing pass on even then.
// Reset (aresetn, synchronous, active low) empties both registers, clears the receive
// window, the counters and the last send time, and sets the interval to 30000 ms.
module latency_probe_framer_top
    import lpf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [7:0]         s_rx_byte,
    input  logic [62:0]        s_now_ms,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [7:0]         m_tx_byte,
    output logic signed [63:0] m_latency_ms,
    output logic               m_last,
    output logic [31:0]        m_frames_sent,
    output logic [31:0]        m_frames_received
);

    // Configuration: the interval register takes a transfer in any cycle.
    logic [16:0] interval_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            interval_reg <= cfg_data;
        end
    end

    // Input register. It holds one accepted item until the processing step takes it.
    logic        in_vld_reg;
    logic        in_type_reg;
    logic [7:0]  in_byte_reg;
    logic [62:0] in_now_reg;

    // Result register. It holds one batch of results: either a whole probe frame,
    // streamed out one byte per transfer, or a single latency measurement.
    logic        out_vld_reg;
    logic        out_kind_reg;
    logic [3:0]  out_idx_reg;
    logic [63:0] out_data_reg;
    logic [7:0]  out_chk_reg;
    logic [31:0] out_sent_reg;
    logic [31:0] out_recv_reg;

    // Block state.
    logic [62:0] last_sent_reg;
    logic [31:0] sent_reg;
    logic [31:0] recv_reg;

    logic        out_last;
    logic        out_done;
    logic        slot_free;
    logic        produces;
    logic        advance;
    logic        send;
    logic [63:0] elapsed;
    logic [63:0] now_ext;
    logic [7:0]  frame_chk;
    logic        byte_wr;
    lpf_rx_hit_t rx_hit;
    logic [3:0]  rx_fill;
    logic [3:0]  time_idx;

    assign now_ext = {1'b0, in_now_reg};

    // A tick sends when the signed elapsed time is not negative and reaches the interval.
    assign elapsed = now_ext - {1'b0, last_sent_reg};
    assign send    = !elapsed[63] && (elapsed >= 64'(interval_reg));

    assign byte_wr = advance && (in_type_reg == REQ_BYTE);

    lpf_rx_window u_rx_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (byte_wr),
        .rx_byte (in_byte_reg),
        .hit     (rx_hit),
        .fill    (rx_fill)
    );

    assign produces  = (in_type_reg == REQ_TICK) ? send : rx_hit.match;
    assign out_last  = (out_kind_reg == KIND_LAT) || (out_idx_reg == IDX_CHK);
    assign out_done  = out_vld_reg && m_ready && out_last;
    assign slot_free = !out_vld_reg || out_done;

    // The held item moves on when it yields nothing, or when the result register is free
    // or hands over its last transfer in this cycle.
    assign advance = in_vld_reg && (slot_free || !produces);
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        frame_chk = MARK0 ^ MARK1;
        for (int i = 0; i < TIME_BYTES; i++) begin
            frame_chk = frame_chk ^ now_ext[8*i +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg <= s_req_type;
            in_byte_reg <= s_rx_byte;
            in_now_reg  <= s_now_ms;
        end
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    // State update happens when the item leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sent_reg <= '0;
            sent_reg      <= '0;
            recv_reg      <= '0;
        end else if (advance && produces) begin
            if (in_type_reg == REQ_TICK) begin
                last_sent_reg <= in_now_reg;
                sent_reg      <= sent_reg + 32'd1;
            end else begin
                recv_reg <= recv_reg + 32'd1;
            end
        end
    end

    // A new batch takes priority; it is only loaded when the previous one is done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            out_idx_reg <= '0;
        end else if (advance && produces) begin
            out_vld_reg <= 1'b1;
            out_idx_reg <= IDX_MARK0;
        end else if (out_vld_reg && m_ready) begin
            if (out_last) begin
                out_vld_reg <= 1'b0;
            end else begin
                out_idx_reg <= out_idx_reg + 4'd1;
            end
        end
        if (advance && produces) begin
            if (in_type_reg == REQ_TICK) begin
                out_kind_reg <= KIND_TX;
                out_data_reg <= now_ext;
                out_chk_reg  <= frame_chk;
                out_sent_reg <= sent_reg + 32'd1;
                out_recv_reg <= recv_reg;
            end else begin
                out_kind_reg <= KIND_LAT;
                out_data_reg <= now_ext - rx_hit.sent_ms;
                out_chk_reg  <= '0;
                out_sent_reg <= sent_reg;
                out_recv_reg <= recv_reg + 32'd1;
            end
        end
    end

    // Frame byte selection: marker bytes, then the time least significant byte first,
    // then the checksum.
    assign time_idx = out_idx_reg - IDX_TIME0;

    always_comb begin
        case (out_idx_reg)
            IDX_MARK0: m_tx_byte = MARK0;
            IDX_MARK1: m_tx_byte = MARK1;
            IDX_CHK:   m_tx_byte = out_chk_reg;
            default:   m_tx_byte = out_data_reg[{time_idx[2:0], 3'b000} +: 8];
        endcase
        if (out_kind_reg == KIND_LAT) begin
            m_tx_byte = '0;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_kind            = out_kind_reg;
    assign m_latency_ms      = (out_kind_reg == KIND_LAT) ? $signed(out_data_reg) : '0;
    assign m_last            = out_last;
    assign m_frames_sent     = out_sent_reg;
    assign m_frames_received = out_recv_reg;

    // A frame never streams past its checksum byte.
    a_idx_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_idx_reg <= IDX_CHK))
        else $error("frame byte index past checksum");

    // A new batch is loaded only into a free result register.
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && produces) |-> slot_free)
        else $error("result batch overwritten");

    // Each sending tick counts exactly once.
    a_sent_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && produces && (in_type_reg == REQ_TICK)) |=>
        (sent_reg == $past(sent_reg) + 32'd1))
        else $error("send counter mismatch");

    // The receive window never holds more than ten bytes between items.
    a_fill_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        rx_fill <= IDX_CHK)
        else $error("receive window overfilled");

endmodule
